// File: rtl/core/isotp_pkg.sv
// Shared types and constants for the ISO-TP receive reassembler.
// Used by the top level and by its port checker; depends on nothing.

package isotp_pkg;

   // Operation selector carried on the request tuser.
   typedef enum logic [1:0] {
      ACT_RX    = 2'd0,
      ACT_READ  = 2'd1,
      ACT_FETCH = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   // Frame type codes from the high nibble of the PCI byte.
   localparam logic [3:0] PCI_SF = 4'd0;
   localparam logic [3:0] PCI_FF = 4'd1;
   localparam logic [3:0] PCI_CF = 4'd2;
   localparam logic [3:0] PCI_FC = 4'd3;

   localparam logic [3:0]  CAN_FRAME_LEN = 4'd8;
   localparam logic [3:0]  SF_MAX_LEN    = 4'd7;
   localparam logic [3:0]  FF_PAYLOAD    = 4'd6;
   localparam logic [3:0]  CF_PAYLOAD    = 4'd7;
   localparam int          LANES         = 8;

   localparam int POS_W     = 12;
   localparam int REQ_W     = 96;
   localparam int RSP_W     = 48;

   // Result bit positions inside rsp_tdata.
   localparam int RSP_ACC_LSB  = 0;
   localparam int RSP_OVR_LSB  = 1;
   localparam int RSP_HELD_LSB = 2;
   localparam int RSP_REM_LSB  = 14;
   localparam int RSP_CMPL_LSB = 26;
   localparam int RSP_RD_LSB   = 27;
   localparam int RSP_FC_LSB   = 35;

   typedef struct packed {
      logic             accepted;
      logic             overrun;
      logic [POS_W-1:0] bytes_held;
      logic [POS_W-1:0] bytes_remaining;
      logic             message_complete;
      logic [POS_W-1:0] fetch_count;
   } rsp_fields_type;

endpackage

// File: rtl/core/isotp_rx_reassembler.sv
// Top level of the ISO-TP receive reassembler: frame decode, counters and
// the byte-lane message store. Depends on isotp_pkg.

// An ISO-TP receive reassembler. Each request transaction carries one
// operation in req_tuser: receive a CAN frame, read one stored byte, or fetch
// the message count and release the counters. Every request produces exactly
// one response transaction with the status after that operation. A request
// is first held in the input register; when the pipeline advances it is
// decoded and applied to the counters and the store while its response is
// loaded into the output register. One request can be taken every cycle
// while the response side keeps up. The message store is eight byte-wide
// memories, one per byte lane (position modulo eight), so a consecutive
// frame writes all of its up to seven bytes in the same cycle and a read fetches
// one row from every lane. The store needs no clearing pass after reset: a
// high-water mark records how far it has ever been written, and a read at or
// beyond that mark returns zero, which matches a store cleared at reset.
// A request is taken immediately after reset. Bytes whose position falls at
// or beyond STORE_BYTES are dropped while the counters keep advancing.

module isotp_rx_reassembler
   import isotp_pkg::*;
#(
   parameter int STORE_BYTES = 4096
) (
   input  logic             clock,
   input  logic             reset,
   // Request: tuser = action[1:0].
   // tdata  = frame_length[3:0], data_0..data_7 [67:4] (8 bits each, data_0
   //          lowest), read_index[79:68], max_bytes[91:80], zero fill[95:92].
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [1:0]       req_tuser,
   input  logic [REQ_W-1:0] req_tdata,
   // Response: tdata = accepted[0], overrun[1], bytes_held[13:2],
   //          bytes_remaining[25:14], message_complete[26], read_data[34:27],
   //          fetch_count[46:35], zero fill[47].
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata
);

   localparam int ROWS  = (STORE_BYTES + LANES - 1) / LANES;
   localparam int ROW_W = $clog2(ROWS);
   localparam int HW_W  = $clog2(STORE_BYTES + 1);

   // Input register.
   logic             s1_valid_ff, s1_valid_in;
   action_type       s1_action_ff;
   logic [REQ_W-1:0] s1_data_ff;

   // Result register.
   logic             s2_valid_ff, s2_valid_in;
   rsp_fields_type   s2_res_ff, s2_res_in;
   logic             s2_rd_ok_ff, s2_rd_ok_in;
   logic [2:0]       s2_lane_ff;

   // Reassembly state.
   logic [POS_W-1:0] fill_ff, fill_in;
   logic [POS_W-1:0] rem_ff, rem_in;
   logic [3:0]       seq_ff, seq_in;
   logic             ovr_ff, ovr_in;
   logic [HW_W-1:0]  hw_ff, hw_in;

   logic adv;
   logic go;

   // Decode of the registered request.
   logic [3:0]       flen;
   logic [3:0]       kind;
   logic [3:0]       info;
   logic [7:0]       fbyte [LANES];
   logic [POS_W-1:0] rd_idx;
   logic [POS_W-1:0] max_lim;
   logic [POS_W-1:0] ff_total;
   logic [3:0]       cf_n;

   // Store write request.
   logic             wr_go;
   logic             wr_ff_sel;
   logic [POS_W-1:0] wr_base;
   logic [3:0]       wr_cnt;
   logic             rd_go;
   logic [7:0]       payload [LANES];
   logic [POS_W:0]   wr_end;
   logic [POS_W:0]   wr_end_cap;

   logic             lane_we    [LANES];
   logic [ROW_W-1:0] lane_row   [LANES];
   logic [7:0]       lane_wdata [LANES];
   logic [7:0]       lane_q     [LANES];
   logic [ROW_W-1:0] rd_row;

   // The pipeline moves as a whole whenever the result register is free or
   // being drained.
   assign adv        = !s2_valid_ff || rsp_tready;
   assign req_tready = !s1_valid_ff || adv;
   assign go         = adv && s1_valid_ff;

   assign s1_valid_in = (req_tvalid && req_tready) ? 1'b1 : (adv ? 1'b0 : s1_valid_ff);
   assign s2_valid_in = adv ? s1_valid_ff : s2_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         fill_ff     <= '0;
         rem_ff      <= '0;
         seq_ff      <= '0;
         ovr_ff      <= 1'b0;
         hw_ff       <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         if (go) begin
            fill_ff <= fill_in;
            rem_ff  <= rem_in;
            seq_ff  <= seq_in;
            ovr_ff  <= ovr_in;
            hw_ff   <= hw_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_action_ff <= action_type'(req_tuser);
         s1_data_ff   <= req_tdata;
      end
      if (go) begin
         s2_res_ff   <= s2_res_in;
         s2_rd_ok_ff <= s2_rd_ok_in;
         s2_lane_ff  <= rd_idx[2:0];
      end
   end

   assign flen    = s1_data_ff[3:0];
   assign kind    = s1_data_ff[11:8];
   assign info    = s1_data_ff[7:4];
   assign rd_idx  = s1_data_ff[79:68];
   assign max_lim = s1_data_ff[91:80];
   assign rd_row  = rd_idx[ROW_W+2:3];

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         fbyte[k] = s1_data_ff[4 + 8*k +: 8];
      end
   end

   assign ff_total = {info, fbyte[1]};
   assign cf_n     = (rem_ff < POS_W'(CF_PAYLOAD)) ? rem_ff[3:0] : CF_PAYLOAD;

   // Operation decode and next state. Checks follow the frame rules in order:
   // frame length, frame type, then the per-type conditions.
   always_comb begin
      fill_in     = fill_ff;
      rem_in      = rem_ff;
      seq_in      = seq_ff;
      ovr_in      = ovr_ff;
      wr_go       = 1'b0;
      wr_ff_sel   = 1'b0;
      wr_base     = '0;
      wr_cnt      = '0;
      rd_go       = 1'b0;
      s2_rd_ok_in = 1'b0;
      s2_res_in   = '0;

      case (s1_action_ff)
         ACT_RX: begin
            if (flen == CAN_FRAME_LEN) begin
               case (kind)
                  PCI_SF: begin
                     if (fill_ff != '0) begin
                        ovr_in = 1'b1;
                     end else if (info <= SF_MAX_LEN) begin
                        s2_res_in.accepted = 1'b1;
                        rem_in  = '0;
                        fill_in = POS_W'(info);
                        wr_go   = 1'b1;
                        wr_cnt  = info;
                     end
                  end
                  PCI_FF: begin
                     if (fill_ff != '0) begin
                        ovr_in = 1'b1;
                     end else begin
                        s2_res_in.accepted = 1'b1;
                        wr_go     = 1'b1;
                        wr_ff_sel = 1'b1;
                        wr_cnt    = FF_PAYLOAD;
                        fill_in   = POS_W'(FF_PAYLOAD);
                        seq_in    = 4'd1;
                        rem_in    = (ff_total > POS_W'(FF_PAYLOAD)) ?
                                    ff_total - POS_W'(FF_PAYLOAD) : '0;
                     end
                  end
                  PCI_CF: begin
                     if (!ovr_ff && seq_ff == info && rem_ff != '0) begin
                        s2_res_in.accepted = 1'b1;
                        wr_go   = 1'b1;
                        wr_base = fill_ff;
                        wr_cnt  = cf_n;
                        fill_in = fill_ff + POS_W'(cf_n);
                        rem_in  = rem_ff - POS_W'(cf_n);
                        seq_in  = seq_ff + 4'd1;
                     end
                  end
                  PCI_FC: begin
                     s2_res_in.accepted = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ACT_READ: begin
            rd_go       = 1'b1;
            s2_rd_ok_in = ({1'b0, rd_idx} < (POS_W+1)'(hw_ff));
         end
         ACT_FETCH: begin
            s2_res_in.fetch_count = (max_lim < fill_ff) ? max_lim : fill_ff;
            ovr_in  = 1'b0;
            fill_in = '0;
            rem_in  = '0;
            seq_in  = '0;
         end
         default: begin
         end
      endcase

      s2_res_in.overrun          = ovr_in;
      s2_res_in.bytes_held       = fill_in;
      s2_res_in.bytes_remaining  = rem_in;
      s2_res_in.message_complete = (fill_in != '0) && (rem_in == '0);
   end

   // A first frame carries its payload from byte 2, the others from byte 1.
   always_comb begin
      for (int k = 0; k < LANES - 1; k++) begin
         payload[k] = wr_ff_sel ? fbyte[k + 2 > LANES - 1 ? LANES - 1 : k + 2]
                                : fbyte[k + 1];
      end
      payload[LANES-1] = '0;
   end

   // Each lane takes the payload byte whose position falls in it.
   always_comb begin
      logic [2:0]     j;
      logic [POS_W:0] pos;
      for (int l = 0; l < LANES; l++) begin
         j             = 3'(l) - wr_base[2:0];
         pos           = {1'b0, wr_base} + (POS_W+1)'(j);
         lane_we[l]    = wr_go && ({1'b0, j} < wr_cnt) &&
                         (pos < (POS_W+1)'(STORE_BYTES));
         lane_row[l]   = pos[ROW_W+2:3];
         lane_wdata[l] = payload[j];
      end
   end

   // The high-water mark follows the furthest byte ever written; the written
   // region always starts at position zero and grows without holes.
   assign wr_end     = {1'b0, wr_base} + (POS_W+1)'(wr_cnt);
   assign wr_end_cap = (wr_end > (POS_W+1)'(STORE_BYTES)) ?
                       (POS_W+1)'(STORE_BYTES) : wr_end;
   assign hw_in      = (wr_go && wr_end_cap > (POS_W+1)'(hw_ff)) ?
                       HW_W'(wr_end_cap) : hw_ff;

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      logic [7:0] mem [ROWS];
      logic [7:0] q_ff;

      always_ff @(posedge clock) begin
         if (go && lane_we[g]) begin
            mem[lane_row[g]] <= lane_wdata[g];
         end
         if (go && rd_go) begin
            q_ff <= mem[rd_row];
         end
      end

      assign lane_q[g] = q_ff;
   end

   assign rsp_tvalid = s2_valid_ff;
   assign rsp_tdata  = {1'b0,
                        s2_res_ff.fetch_count,
                        s2_rd_ok_ff ? lane_q[s2_lane_ff] : 8'd0,
                        s2_res_ff.message_complete,
                        s2_res_ff.bytes_remaining,
                        s2_res_ff.bytes_held,
                        s2_res_ff.overrun,
                        s2_res_ff.accepted};

endmodule

// File: rtl/core/isotp_chk.sv
// Port-level checker for the ISO-TP receive reassembler and its bind.
// Depends on isotp_pkg and on the port list of isotp_rx_reassembler.

module isotp_chk
   import isotp_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_tvalid,
   input logic             rsp_tready,
   input logic [RSP_W-1:0] rsp_tdata
);

   logic             acc;
   logic             ovr;
   logic [POS_W-1:0] held;
   logic [POS_W-1:0] remain;
   logic             cmpl;
   logic [7:0]       rdat;
   logic [POS_W-1:0] fcnt;

   assign acc    = rsp_tdata[RSP_ACC_LSB];
   assign ovr    = rsp_tdata[RSP_OVR_LSB];
   assign held   = rsp_tdata[RSP_HELD_LSB +: POS_W];
   assign remain = rsp_tdata[RSP_REM_LSB +: POS_W];
   assign cmpl   = rsp_tdata[RSP_CMPL_LSB];
   assign rdat   = rsp_tdata[RSP_RD_LSB +: 8];
   assign fcnt   = rsp_tdata[RSP_FC_LSB +: POS_W];

   // No response is offered in the cycle after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response offered right after reset");

   // A stalled response holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // Completion is reported only with bytes held and none outstanding.
   a_complete: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && cmpl |-> held != '0 && remain == '0)
      else $error("completion flag disagrees with counters");

   // A fetch hands out bytes and leaves all counters released.
   a_fetch_release: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && fcnt != '0 |-> held == '0 && remain == '0 && !ovr && !acc)
      else $error("fetch did not release the counters");

   // Read data appears only on a read, which never accepts or fetches.
   a_read_only: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rdat != 8'd0 |-> !acc && fcnt == '0)
      else $error("read data on a non-read response");

endmodule

bind isotp_rx_reassembler isotp_chk u_isotp_chk (.*);
